FILE: hw/rtl/tcsm_pkg.sv
// Shared types, codes and helpers for the TCP connection state machine.
// No dependencies; imported by every module of the block.
package tcsm_pkg;

  localparam int unsigned SeqW    = 32;
  localparam int unsigned WinW    = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned FlagW   = 8;
  localparam int unsigned WakeW   = 4;
  localparam int unsigned InDataW = 144;  // 140 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 48;  // 47 bits of fields, padded to bytes

  // segment flag bit positions
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagAck = 4;

  // wake mask bit positions
  localparam int unsigned WakeSend    = 0;
  localparam int unsigned WakeAccept  = 1;
  localparam int unsigned WakeConnect = 2;
  localparam int unsigned WakeRecv    = 3;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_RECV    = 4'd2,
    ST_SYN_SENT    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_CLOSE_WAIT  = 4'd5,
    ST_LAST_ACK    = 4'd6,
    ST_FIN_WAIT_1  = 4'd7,
    ST_FIN_WAIT_2  = 4'd8,
    ST_TIME_WAIT   = 4'd9
  } conn_state_e;

  typedef enum logic [2:0] {
    CTRL_NONE   = 3'd0,
    CTRL_ACK    = 3'd1,
    CTRL_SYNACK = 3'd2,
    CTRL_FIN    = 3'd3,
    CTRL_RST    = 3'd4
  } ctrl_e;

  typedef enum logic {
    REQ_SEGMENT = 1'b0,
    REQ_FORCE   = 1'b1
  } req_e;

  typedef struct packed {
    req_e             req_type;
    logic [3:0]       forced_state;
    logic [FlagW-1:0] seg_flags;
    logic [SeqW-1:0]  seg_seq;
    logic [SeqW-1:0]  seg_seq_end;
    logic [SeqW-1:0]  seg_ack;
    logic [WinW-1:0]  seg_window;
    logic [LenW-1:0]  payload_len;
  } item_t;

  typedef struct packed {
    conn_state_e     state;
    logic [SeqW-1:0] rcv_next;
    logic [SeqW-1:0] send_unacked;
    logic [SeqW-1:0] send_next;
    logic [WinW-1:0] send_window;
  } ctx_t;

  typedef struct packed {
    ctrl_e            send_ctrl;
    logic             spawn_child;
    logic [SeqW-1:0]  child_rcv_next;
    logic             deliver_payload;
    logic [WakeW-1:0] wake_mask;
    logic             unhash_conn;
    logic             start_timewait;
    conn_state_e      state_now;
  } result_t;

  // a <= b in wrap-around sequence order
  function automatic logic seq_le(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] diff;
    diff = b - a;
    return ~diff[SeqW-1];
  endfunction

  // a < b in wrap-around sequence order
  function automatic logic seq_lt(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] diff;
    diff = a - b;
    return diff[SeqW-1];
  endfunction

endpackage

FILE: hw/rtl/tcsm_apb_regs.sv
// APB configuration register: initial send sequence number.
// Depends on tcsm_pkg.
module tcsm_apb_regs
  import tcsm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [SeqW-1:0] iss_o
);

  localparam logic RegIss = 1'b0;  // word index of initial_send_seq

  logic [SeqW-1:0] iss_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
    end else if (wr_en && paddr[2] == RegIss) begin
      iss_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == RegIss) ? iss_q : 32'd0;
  assign iss_o  = iss_q;

endmodule

FILE: hw/rtl/tcsm_step.sv
// Next-state and result logic for one request against the connection context.
// Depends on tcsm_pkg.
module tcsm_step
  import tcsm_pkg::*;
(
  input  item_t           item_i,
  input  ctx_t            ctx_i,
  input  logic [SeqW-1:0] iss_i,
  output ctx_t            ctx_o,
  output result_t         res_o
);

  logic has_pl, has_fin, has_syn, has_ack;
  logic win_new_ok, win_old_ok, win_est_ok;
  logic [SeqW-1:0] iss_plus1;

  assign has_pl    = item_i.payload_len != '0;
  assign has_fin   = item_i.seg_flags[FlagFin];
  assign has_syn   = item_i.seg_flags[FlagSyn];
  assign has_ack   = item_i.seg_flags[FlagAck];
  assign iss_plus1 = iss_i + SeqW'(1);

  // window check with send_unacked already moved to ack, and with the old value
  assign win_new_ok = seq_le(item_i.seg_ack, ctx_i.send_next);
  assign win_old_ok = seq_le(ctx_i.send_unacked, item_i.seg_ack) && win_new_ok;
  assign win_est_ok = has_pl ? win_new_ok : win_old_ok;

  always_comb begin
    ctx_o = ctx_i;
    res_o = '0;
    if (item_i.req_type == REQ_FORCE) begin
      if (item_i.forced_state <= ST_TIME_WAIT) begin
        ctx_o.state = conn_state_e'(item_i.forced_state);
      end
    end else begin
      case (ctx_i.state)
        ST_CLOSED: begin
          res_o.send_ctrl = CTRL_RST;
        end
        ST_LISTEN: begin
          if (has_syn) begin
            res_o.spawn_child    = 1'b1;
            res_o.child_rcv_next = item_i.seg_seq_end;
            res_o.send_ctrl      = CTRL_SYNACK;
          end
        end
        ST_SYN_RECV: begin
          if (has_ack) begin
            ctx_o.state        = ST_ESTABLISHED;
            ctx_o.rcv_next     = item_i.seg_seq_end;
            ctx_o.send_unacked = item_i.seg_ack;
            res_o.wake_mask[WakeAccept] = 1'b1;
            if (win_old_ok) begin
              ctx_o.send_window = item_i.seg_window;
              res_o.wake_mask[WakeSend] = ctx_i.send_window == '0;
            end
          end
        end
        ST_SYN_SENT: begin
          if (has_syn && has_ack && item_i.seg_ack == iss_plus1) begin
            ctx_o.state        = ST_ESTABLISHED;
            ctx_o.rcv_next     = item_i.seg_seq_end;
            ctx_o.send_unacked = item_i.seg_ack;
            res_o.send_ctrl    = CTRL_ACK;
            res_o.wake_mask[WakeConnect] = 1'b1;
            if (win_old_ok) begin
              ctx_o.send_window = item_i.seg_window;
              res_o.wake_mask[WakeSend] = ctx_i.send_window == '0;
            end
          end else begin
            res_o.send_ctrl = CTRL_RST;
          end
        end
        ST_ESTABLISHED: begin
          if (has_pl || has_fin) begin
            ctx_o.send_unacked = item_i.seg_ack;
            res_o.send_ctrl    = CTRL_ACK;
            res_o.wake_mask[WakeRecv] = 1'b1;
            // payload and FIN together run two window updates back to back
            if (win_est_ok) begin
              ctx_o.send_window = item_i.seg_window;
              res_o.wake_mask[WakeSend] = (ctx_i.send_window == '0) ||
                                          (has_pl && has_fin && item_i.seg_window == '0);
            end
          end
          if (has_pl) begin
            res_o.deliver_payload = 1'b1;
            ctx_o.rcv_next = ctx_i.rcv_next + SeqW'(item_i.payload_len);
          end
          if (has_fin) begin
            ctx_o.rcv_next = item_i.seg_seq_end;
            ctx_o.state    = ST_CLOSE_WAIT;
          end
        end
        ST_CLOSE_WAIT: begin
          res_o.send_ctrl = CTRL_FIN;
          ctx_o.state     = ST_LAST_ACK;
        end
        ST_FIN_WAIT_1: begin
          if (has_ack) begin
            ctx_o.state = ST_FIN_WAIT_2;
          end
        end
        ST_FIN_WAIT_2: begin
          if (has_fin || has_ack) begin
            res_o.send_ctrl      = CTRL_ACK;
            res_o.start_timewait = 1'b1;
            ctx_o.state          = ST_TIME_WAIT;
            ctx_o.send_next      = item_i.seg_ack;
            ctx_o.rcv_next       = item_i.seg_seq + SeqW'(1);
            if (seq_lt(ctx_i.send_unacked, item_i.seg_ack)) begin
              ctx_o.send_unacked = item_i.seg_ack;
            end
          end
        end
        ST_LAST_ACK: begin
          if (has_ack) begin
            ctx_o.state       = ST_CLOSED;
            res_o.unhash_conn = 1'b1;
          end
        end
        ST_TIME_WAIT: begin
          res_o.unhash_conn = 1'b1;
        end
        default: begin
        end
      endcase
    end
    res_o.state_now = ctx_o.state;
  end

endmodule

FILE: hw/rtl/tcp_connection_state_machine_top.sv
// TCP connection state machine, top level: input register, step logic, result register.
// A request is registered at the input, then its result is held in the result register.
// Throughput: 1 request per cycle unless the result stream stalls; the connection
// context is updated in the same cycle a request moves to the result register.
// Reset (async, active low) returns the connection to CLOSED with all sequence state zero.
// Depends on tcsm_pkg, tcsm_apb_regs, tcsm_step.
module tcp_connection_state_machine_top
  import tcsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request: tuser = req_type
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: forced_state(4), seg_flags(8), seg_seq(32), seg_seq_end(32),
  // seg_ack(32), seg_window(16), payload_len(16), zero pad(4)
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  // result
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: send_ctrl(3), spawn_child(1), child_rcv_next(32),
  // deliver_payload(1), wake_mask(4), unhash_conn(1), start_timewait(1),
  // state_now(4), zero pad(1)
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic            in_valid_q;
  item_t           item_q, item_d;
  logic            out_valid_q;
  result_t         out_q, res;
  ctx_t            ctx_q, ctx_d;
  logic [SeqW-1:0] iss;
  logic            advance, fire, in_take;

  tcsm_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .iss_o  (iss)
  );

  tcsm_step u_step (
    .item_i(item_q),
    .ctx_i (ctx_q),
    .iss_i (iss),
    .ctx_o (ctx_d),
    .res_o (res)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.req_type     = req_e'(s_axis_tuser[0]);
    item_d.forced_state = s_axis_tdata[3:0];
    item_d.seg_flags    = s_axis_tdata[11:4];
    item_d.seg_seq      = s_axis_tdata[43:12];
    item_d.seg_seq_end  = s_axis_tdata[75:44];
    item_d.seg_ack      = s_axis_tdata[107:76];
    item_d.seg_window   = s_axis_tdata[123:108];
    item_d.payload_len  = s_axis_tdata[139:124];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctx_q       <= '{state: ST_CLOSED, default: '0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        ctx_q       <= ctx_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.state_now, out_q.start_timewait, out_q.unhash_conn,
                          out_q.wake_mask, out_q.deliver_payload, out_q.child_rcv_next,
                          out_q.spawn_child, out_q.send_ctrl};

  // a result must never be overwritten while it waits downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while stalled");

  // context only moves when a request is processed
  a_ctx_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(ctx_q))
    else $error("connection context changed without a request");

  // each processed request leaves a valid result
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed request produced no result");

  // a forced state request carries nothing but the state
  a_force_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.req_type == REQ_FORCE) |=>
      (out_q.send_ctrl == CTRL_NONE && !out_q.spawn_child && out_q.wake_mask == '0 &&
       !out_q.unhash_conn && !out_q.start_timewait && !out_q.deliver_payload))
    else $error("forced state request produced side effects");

  // stalled input register only while a request is actually held
  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input blocked without a pending request");

endmodule

FILE: test/tb_tcp_connection_state_machine_top.sv
// Self-checking bench for tcp_connection_state_machine_top: directed state walks, then random
// traffic shaped by the predicted connection state, with random idle and stall on both streams.
// Depends on tcsm_pkg and the block's RTL.
module tb_tcp_connection_state_machine_top;
  import tcsm_pkg::*;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned RandomItems = 1900;
  localparam logic [2:0]  RegInitSeq  = 3'd0;  // byte address of initial_send_seq

  localparam logic [FlagW-1:0] SegFin = 8'(1 << FlagFin);
  localparam logic [FlagW-1:0] SegSyn = 8'(1 << FlagSyn);
  localparam logic [FlagW-1:0] SegAck = 8'(1 << FlagAck);

  logic                clk;
  logic                rst_n;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // predicted connection context
  conn_state_e     st_now  = ST_CLOSED;
  logic [SeqW-1:0] rx_next = '0;
  logic [SeqW-1:0] tx_una  = '0;
  logic [SeqW-1:0] tx_next = '0;
  logic [WinW-1:0] tx_wnd  = '0;
  logic [SeqW-1:0] iss_cfg = '0;

  result_t     actions_q[$];
  int unsigned mismatches = 0;
  bit          quiet = 1'b0;
  int unsigned rx_hold = 0;

  tcp_connection_state_machine_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // mostly back to back, now and then a short or long hole
  function automatic int unsigned pick_gap();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (quiet || dice < 65) return 0;
    if (dice < 90) return $urandom_range(1, 3);
    if (dice < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit seq_not_after(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = b - a;
    return !d[SeqW-1];
  endfunction

  // window takes the peer's value only when una <= ack <= nxt
  function automatic logic [WakeW-1:0] take_window(input logic [SeqW-1:0] ack,
                                                    input logic [WinW-1:0] win);
    logic [WakeW-1:0] wk;
    wk = '0;
    if (seq_not_after(tx_una, ack) && seq_not_after(ack, tx_next)) begin
      if (tx_wnd == '0) wk[WakeSend] = 1'b1;
      tx_wnd = win;
    end
    return wk;
  endfunction

  function automatic result_t next_connection_actions(input item_t it);
    result_t         r;
    logic [SeqW-1:0] lag;
    r = '0;
    if (it.req_type == REQ_FORCE) begin
      if (it.forced_state <= ST_TIME_WAIT) st_now = conn_state_e'(it.forced_state);
    end else begin
      case (st_now)
        ST_CLOSED: r.send_ctrl = CTRL_RST;
        ST_LISTEN: begin
          if (it.seg_flags[FlagSyn]) begin
            r.spawn_child    = 1'b1;
            r.child_rcv_next = it.seg_seq_end;
            r.send_ctrl      = CTRL_SYNACK;
          end
        end
        ST_SYN_RECV: begin
          if (it.seg_flags[FlagAck]) begin
            st_now = ST_ESTABLISHED;
            rx_next = it.seg_seq_end;
            r.wake_mask |= take_window(it.seg_ack, it.seg_window);
            tx_una = it.seg_ack;
            r.wake_mask[WakeAccept] = 1'b1;
          end
        end
        ST_SYN_SENT: begin
          if (it.seg_flags[FlagSyn] && it.seg_flags[FlagAck] &&
              it.seg_ack == iss_cfg + 32'd1) begin
            rx_next = it.seg_seq_end;
            r.wake_mask |= take_window(it.seg_ack, it.seg_window);
            tx_una = it.seg_ack;
            st_now = ST_ESTABLISHED;
            r.send_ctrl = CTRL_ACK;
            r.wake_mask[WakeConnect] = 1'b1;
          end else begin
            r.send_ctrl = CTRL_RST;
          end
        end
        ST_ESTABLISHED: begin
          // data first, then FIN, both in the same item
          if (it.payload_len != '0) begin
            r.deliver_payload = 1'b1;
            rx_next = rx_next + 32'(it.payload_len);
            tx_una = it.seg_ack;
            r.wake_mask |= take_window(it.seg_ack, it.seg_window);
            r.wake_mask[WakeRecv] = 1'b1;
            r.send_ctrl = CTRL_ACK;
          end
          if (it.seg_flags[FlagFin]) begin
            rx_next = it.seg_seq_end;
            r.wake_mask |= take_window(it.seg_ack, it.seg_window);
            tx_una = it.seg_ack;
            r.send_ctrl = CTRL_ACK;
            st_now = ST_CLOSE_WAIT;
            r.wake_mask[WakeRecv] = 1'b1;
          end
        end
        ST_CLOSE_WAIT: begin
          r.send_ctrl = CTRL_FIN;
          st_now = ST_LAST_ACK;
        end
        ST_FIN_WAIT_1: begin
          if (it.seg_flags[FlagAck]) st_now = ST_FIN_WAIT_2;
        end
        ST_FIN_WAIT_2: begin
          if (it.seg_flags[FlagFin] || it.seg_flags[FlagAck]) begin
            r.send_ctrl = CTRL_ACK;
            st_now = ST_TIME_WAIT;
            tx_next = it.seg_ack;
            rx_next = it.seg_seq + 32'd1;
            lag = tx_una - it.seg_ack;
            if (lag[SeqW-1]) tx_una = it.seg_ack;
            r.start_timewait = 1'b1;
          end
        end
        ST_LAST_ACK: begin
          if (it.seg_flags[FlagAck]) begin
            st_now = ST_CLOSED;
            r.unhash_conn = 1'b1;
          end
        end
        ST_TIME_WAIT: r.unhash_conn = 1'b1;
        default: ;
      endcase
    end
    r.state_now = st_now;
    return r;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned idle;
    idle = pick_gap();
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req_type;
    s_axis_tdata  <= {4'b0, it.payload_len, it.seg_window, it.seg_ack, it.seg_seq_end,
                      it.seg_seq, it.seg_flags, it.forced_state};
    do @(posedge clk); while (!s_axis_tready);
    actions_q.push_back(next_connection_actions(it));
  endtask

  task automatic send_seg(input logic [FlagW-1:0] flags, input logic [SeqW-1:0] seq,
                          input logic [SeqW-1:0] seq_end, input logic [SeqW-1:0] ack,
                          input logic [WinW-1:0] win, input logic [LenW-1:0] plen);
    item_t it;
    it.req_type     = REQ_SEGMENT;
    it.forced_state = 4'($urandom);
    it.seg_flags    = flags;
    it.seg_seq      = seq;
    it.seg_seq_end  = seq_end;
    it.seg_ack      = ack;
    it.seg_window   = win;
    it.payload_len  = plen;
    send_item(it);
  endtask

  task automatic send_force(input logic [3:0] st);
    item_t        it;
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    it.req_type     = REQ_FORCE;
    it.forced_state = st;
    send_item(it);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (actions_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves psel high so a following transfer can start in the same step
  task automatic apb_xfer(input logic wr, input logic [31:0] v, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RegInitSeq;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rd = prdata;
      @(posedge clk);
    end while (!pready);
  endtask

  task automatic program_iss(input logic [31:0] v);
    logic [31:0] seen;
    apb_xfer(1'b1, v, seen);
    iss_cfg = v;
    apb_xfer(1'b0, '0, seen);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen !== v) begin
      $error("initial_send_seq readback: expected %h, got %h", v, seen);
      mismatches++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_action(input logic [OutDataW-1:0] got);
    result_t want;
    if (actions_q.size() == 0) begin
      $error("result with no request outstanding: tdata %h", got);
      mismatches++;
      return;
    end
    want = actions_q.pop_front();
    check_field("send_ctrl",       32'(want.send_ctrl),       32'(got[2:0]));
    check_field("spawn_child",     32'(want.spawn_child),     32'(got[3]));
    check_field("child_rcv_next",  want.child_rcv_next,       got[35:4]);
    check_field("deliver_payload", 32'(want.deliver_payload), 32'(got[36]));
    check_field("wake_mask",       32'(want.wake_mask),       32'(got[40:37]));
    check_field("unhash_conn",     32'(want.unhash_conn),     32'(got[41]));
    check_field("start_timewait",  32'(want.start_timewait),  32'(got[42]));
    check_field("state_now",       32'(want.state_now),       32'(got[46:43]));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready) check_action(m_axis_tdata);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_hold = pick_gap();
      end
    end
  end

  function automatic logic [SeqW-1:0] pick_ack();
    case ($urandom_range(0, 6))
      0: return tx_una;
      1: return tx_next;
      2: return tx_una + 32'($urandom_range(0, 2000));
      3: return tx_next + 32'd1;
      4: return tx_una - 32'd1;
      5: return iss_cfg + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WinW-1:0] pick_window();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 25) return '0;
    if (dice < 35) return '1;
    return 16'($urandom);
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 30) return '0;
    if (dice < 80) return 16'($urandom_range(1, 1500));
    if (dice < 90) return '1;
    return 16'($urandom);
  endfunction

  // mostly the segment the current state is waiting for, plus random forces and noise
  task automatic craft_item(output item_t it);
    int unsigned dice;
    it.req_type     = REQ_SEGMENT;
    it.forced_state = 4'($urandom);
    it.seg_flags    = 8'($urandom);
    it.seg_seq      = $urandom;
    it.seg_seq_end  = $urandom;
    it.seg_ack      = $urandom;
    it.seg_window   = 16'($urandom);
    it.payload_len  = 16'($urandom);
    dice = $urandom_range(0, 99);
    if (dice < 6) begin
      it.req_type = REQ_FORCE;
    end else if (dice >= 12) begin
      it.seg_ack     = pick_ack();
      it.seg_window  = pick_window();
      it.payload_len = pick_len();
      it.seg_seq     = rx_next + 32'($urandom_range(0, 3000));
      it.seg_seq_end = it.seg_seq + 32'(it.payload_len);
      dice = $urandom_range(0, 99);
      case (st_now)
        ST_CLOSED: begin
          if (dice < 80) begin
            it.req_type = REQ_FORCE;
            case ($urandom_range(0, 4))
              0: it.forced_state = ST_LISTEN;
              1: it.forced_state = ST_SYN_SENT;
              2: it.forced_state = ST_FIN_WAIT_1;
              3: it.forced_state = ST_SYN_RECV;
              default: it.forced_state = ST_ESTABLISHED;
            endcase
          end
        end
        ST_LISTEN: begin
          if (dice < 25) begin
            it.req_type = REQ_FORCE;
            it.forced_state = ST_SYN_RECV;
          end else begin
            it.seg_flags[FlagSyn] = (dice < 85);
          end
        end
        ST_SYN_RECV: it.seg_flags[FlagAck] = (dice < 85);
        ST_SYN_SENT: begin
          if (dice < 75) begin
            it.seg_flags[FlagSyn] = 1'b1;
            it.seg_flags[FlagAck] = 1'b1;
            it.seg_ack = iss_cfg + 32'd1;
          end
        end
        ST_ESTABLISHED: begin
          if (dice < 5) begin
            it.req_type = REQ_FORCE;
            it.forced_state = ST_FIN_WAIT_1;
          end else begin
            it.seg_flags[FlagFin] = (dice < 15);
          end
        end
        ST_LAST_ACK, ST_FIN_WAIT_1: it.seg_flags[FlagAck] = (dice < 80);
        ST_FIN_WAIT_2: begin
          if (dice < 40) begin
            it.seg_flags[FlagFin] = 1'b1;
          end else if (dice < 80) begin
            it.seg_flags[FlagAck] = 1'b1;
          end else begin
            it.seg_flags[FlagFin] = 1'b0;
            it.seg_flags[FlagAck] = 1'b0;
          end
        end
        ST_TIME_WAIT: begin
          if (dice < 50) begin
            it.req_type = REQ_FORCE;
            it.forced_state = (dice < 25) ? ST_CLOSED : ST_LISTEN;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic test_closed_and_forced();
    send_seg('1, '1, '1, '1, '1, '1);
    send_force(4'hF);  // beyond TIME_WAIT, state must hold
    send_force(ST_TIME_WAIT);
    send_seg('0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_passive_open();
    send_force(ST_LISTEN);
    send_seg(SegAck, 32'h1000, 32'h1001, '0, '0, '0);
    send_seg(SegSyn, 32'h1000, 32'hFFFF_FFFF, '0, '0, '0);
    send_force(ST_SYN_RECV);
    send_seg(SegAck, 32'h1001, 32'h2000, '0, 16'd512, '0);
    send_seg('0, 32'h2000, 32'h2000, '0, '0, '1);
    send_seg(SegFin | SegAck, 32'h2000, 32'h3001, '0, 16'd1024, '0);
    send_seg('0, '0, '0, '0, '0, '0);
    send_seg('0, '0, '0, '0, '0, '0);
    send_seg(SegAck, '0, '0, '0, '0, '0);
  endtask

  task automatic test_active_open();
    settle();
    program_iss('1);  // expected ack wraps to zero
    send_force(ST_SYN_SENT);
    send_seg(SegSyn, 32'h10, 32'h11, '0, 16'd100, '0);
    send_seg(SegSyn | SegAck, 32'h10, 32'h11, '0, 16'd100, '0);
    send_seg(SegFin, 32'h11, 32'h76, '0, '1, 16'd100);
  endtask

  task automatic test_active_close();
    send_force(ST_FIN_WAIT_1);
    send_seg(SegFin, '0, '0, '0, '0, '0);
    send_seg(SegAck, '0, '0, '0, '0, '0);
    send_seg(SegSyn, '0, '0, '0, '0, '0);
    send_seg(SegFin, '1, '1, '1, '1, '0);
    send_seg('0, '0, '0, '0, '0, '0);
    send_force(ST_CLOSED);
  endtask

  task automatic test_random_traffic();
    item_t       it;
    int unsigned n;
    for (n = 0; n < RandomItems; n++) begin
      quiet = ((n / 128) % 4 == 3);
      if (n % 400 == 0) begin
        settle();
        case ((n / 400) % 4)
          0: program_iss('0);
          1: program_iss('1);
          default: program_iss($urandom);
        endcase
      end
      craft_item(it);
      send_item(it);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_closed_and_forced();
    test_passive_open();
    test_active_open();
    test_active_close();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && actions_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
